// ----- sv/ctsc_pkg.sv -----
// ctsc_pkg: shared types, codes, constants and character-class helpers
// for the source token scanner. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctsc_pkg;

  localparam int LINE_BITS   = 24;
  localparam int LENGTH_BITS = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_LOW_E      = 8'h65;
  localparam logic [7:0] CH_UP_E       = 8'h45;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_NL         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_VT         = 8'h0B;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PCT        = 8'h25;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_CARET      = 8'h5E;

  typedef enum logic [5:0] {
    TK_IDENT   = 6'd0,  TK_NUMBER = 6'd1,  TK_STRING = 6'd2,  TK_CHAR   = 6'd3,
    TK_END     = 6'd4,  TK_DIV_EQ = 6'd5,  TK_DIV    = 6'd6,  TK_INC    = 6'd7,
    TK_ADD_EQ  = 6'd8,  TK_ADD    = 6'd9,  TK_DEC    = 6'd10, TK_SUB_EQ = 6'd11,
    TK_SUB     = 6'd12, TK_MUL_EQ = 6'd13, TK_MUL    = 6'd14, TK_MOD_EQ = 6'd15,
    TK_MOD     = 6'd16, TK_SHL_EQ = 6'd17, TK_SHL    = 6'd18, TK_LT     = 6'd19,
    TK_SHR_EQ  = 6'd20, TK_SHR    = 6'd21, TK_GT     = 6'd22, TK_EQ_EQ  = 6'd23,
    TK_ASSIGN  = 6'd24, TK_NE     = 6'd25, TK_NOT    = 6'd26, TK_LOR    = 6'd27,
    TK_OR_EQ   = 6'd28, TK_OR     = 6'd29, TK_LAND   = 6'd30, TK_AND_EQ = 6'd31,
    TK_AND     = 6'd32, TK_XOR_EQ = 6'd33, TK_XOR    = 6'd34
  } tok_kind_t;

  typedef enum logic [4:0] {
    MD_IDLE, MD_IDENT, MD_NINT, MD_NFRAC, MD_NEXP, MD_STR, MD_CMT, MD_CMTSTAR,
    MD_DBLANK, MD_DDIG, MD_DREST, MD_SLASH, MD_PLUS, MD_MINUS, MD_STAR, MD_PCT,
    MD_LT, MD_LTLT, MD_GT, MD_GTGT, MD_EQ, MD_BANG, MD_BAR, MD_AMP, MD_CARET
  } scan_mode_t;

  typedef struct packed {
    logic [5:0]             token_kind;
    logic [7:0]             char_value;
    logic [LINE_BITS-1:0]   line_number;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t mk_res(tok_kind_t kind, logic [7:0] ch,
                                     logic [LINE_BITS-1:0] line,
                                     logic [LENGTH_BITS-1:0] len);
    result_t r;
    r.token_kind   = kind;
    r.char_value   = ch;
    r.line_number  = line;
    r.token_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic tok_kind_t short_kind(scan_mode_t m);
    tok_kind_t k;
    unique case (m)
      MD_SLASH: k = TK_DIV;
      MD_PLUS:  k = TK_ADD;
      MD_MINUS: k = TK_SUB;
      MD_STAR:  k = TK_MUL;
      MD_PCT:   k = TK_MOD;
      MD_LT:    k = TK_LT;
      MD_LTLT:  k = TK_SHL;
      MD_GT:    k = TK_GT;
      MD_GTGT:  k = TK_SHR;
      MD_EQ:    k = TK_ASSIGN;
      MD_BANG:  k = TK_NOT;
      MD_BAR:   k = TK_OR;
      MD_AMP:   k = TK_AND;
      default:  k = TK_XOR;
    endcase
    return k;
  endfunction

  // TK_IDENT stands for no two-character match
  function automatic tok_kind_t long_kind(scan_mode_t m, logic [7:0] c);
    tok_kind_t k;
    k = TK_IDENT;
    unique case (m)
      MD_SLASH: if (c == CH_EQ) k = TK_DIV_EQ;
      MD_PLUS: begin
        if (c == CH_PLUS) k = TK_INC;
        else if (c == CH_EQ) k = TK_ADD_EQ;
      end
      MD_MINUS: begin
        if (c == CH_MINUS) k = TK_DEC;
        else if (c == CH_EQ) k = TK_SUB_EQ;
      end
      MD_STAR:  if (c == CH_EQ) k = TK_MUL_EQ;
      MD_PCT:   if (c == CH_EQ) k = TK_MOD_EQ;
      MD_LTLT:  if (c == CH_EQ) k = TK_SHL_EQ;
      MD_GTGT:  if (c == CH_EQ) k = TK_SHR_EQ;
      MD_EQ:    if (c == CH_EQ) k = TK_EQ_EQ;
      MD_BANG:  if (c == CH_EQ) k = TK_NE;
      MD_BAR: begin
        if (c == CH_BAR) k = TK_LOR;
        else if (c == CH_EQ) k = TK_OR_EQ;
      end
      MD_AMP: begin
        if (c == CH_AMP) k = TK_LAND;
        else if (c == CH_EQ) k = TK_AND_EQ;
      end
      MD_CARET: if (c == CH_EQ) k = TK_XOR_EQ;
      default: k = TK_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- sv/ctsc_in_if.sv -----
// ctsc_in_if: input channel, one source character per item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ctsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface
`default_nettype wire

// ----- sv/ctsc_out_if.sv -----
// ctsc_out_if: result channel, one token result per item.
// Depends on ctsc_pkg for the line and length widths.
`timescale 1ns / 1ps
`default_nettype none
interface ctsc_out_if;
  logic                            valid;
  logic                            ready;
  logic [5:0]                      token_kind;
  logic [7:0]                      char_value;
  logic [ctsc_pkg::LINE_BITS-1:0]   line_number;
  logic [ctsc_pkg::LENGTH_BITS-1:0] token_length;
  logic                            last_of_run;

  modport source (output valid, output token_kind, output char_value, output line_number,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input char_value, input line_number,
                input token_length, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- sv/ctsc_core.sv -----
// ctsc_core: scanner state registers and the per-character next-state logic;
// produces up to two results per accepted item. Depends on ctsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctsc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      c,
  input  wire logic            eoi,
  output ctsc_pkg::push_t      push
);

  localparam int LB = ctsc_pkg::LINE_BITS;
  localparam int NB = ctsc_pkg::LENGTH_BITS;
  localparam int WB = ctsc_pkg::LINE_BITS + 4;

  ctsc_pkg::scan_mode_t mode_r, mode_nxt;
  logic [NB-1:0]        len_r, len_nxt;
  logic [LB-1:0]        line_r, line_nxt;
  logic [LB-1:0]        dval_r, dval_nxt;
  logic                 ddig_r, ddig_nxt;
  logic                 quote_r, quote_nxt;
  logic                 esc_r, esc_nxt;

  logic [NB-1:0]        len_inc;
  logic [WB-1:0]        dval_wide;
  logic [LB-1:0]        dval_add;
  logic [7:0]           close_ch;
  ctsc_pkg::tok_kind_t  lk, sk;
  logic                 fin_v, beg_v, restart, apply, count_nl;
  ctsc_pkg::result_t    fin, beg;
  logic [LB-1:0]        line_app;

  assign len_inc   = (len_r == ctsc_pkg::LEN_MAX) ? len_r : len_r + NB'(1);
  assign dval_wide = WB'({dval_r, 3'b000}) + WB'({dval_r, 1'b0}) + WB'(c[3:0]);
  assign dval_add  = (dval_wide > WB'(ctsc_pkg::LINE_MAX)) ? ctsc_pkg::LINE_MAX
                                                          : dval_wide[LB-1:0];
  assign close_ch  = quote_r ? ctsc_pkg::CH_SQUOTE : ctsc_pkg::CH_DQUOTE;
  assign lk        = ctsc_pkg::long_kind(mode_r, c);
  assign sk        = ctsc_pkg::short_kind(mode_r);
  assign line_app  = ddig_r ? dval_r : line_r;

  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    dval_nxt  = dval_r;
    ddig_nxt  = ddig_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    fin_v     = 1'b0;
    beg_v     = 1'b0;
    fin       = ctsc_pkg::mk_res(ctsc_pkg::TK_IDENT, 8'h00, line_r, len_r);
    beg       = fin;
    restart   = 1'b0;
    apply     = 1'b0;
    count_nl  = (c == ctsc_pkg::CH_NL);

    if (eoi) begin
      count_nl = 1'b0;
      unique case (mode_r) inside
        ctsc_pkg::MD_IDLE, ctsc_pkg::MD_CMT, ctsc_pkg::MD_CMTSTAR: begin
        end
        ctsc_pkg::MD_IDENT: begin
          fin_v = 1'b1;
          fin   = ctsc_pkg::mk_res(ctsc_pkg::TK_IDENT, 8'h00, line_r, len_r);
        end
        ctsc_pkg::MD_NINT, ctsc_pkg::MD_NFRAC, ctsc_pkg::MD_NEXP: begin
          fin_v = 1'b1;
          fin   = ctsc_pkg::mk_res(ctsc_pkg::TK_NUMBER, 8'h00, line_r, len_r);
        end
        ctsc_pkg::MD_STR: begin
          fin_v = 1'b1;
          fin   = ctsc_pkg::mk_res(ctsc_pkg::TK_STRING, 8'h00, line_r, len_r);
        end
        ctsc_pkg::MD_DBLANK, ctsc_pkg::MD_DDIG, ctsc_pkg::MD_DREST: apply = 1'b1;
        default: begin
          fin_v = 1'b1;
          fin   = ctsc_pkg::mk_res(sk, 8'h00, line_r, len_r);
        end
      endcase
      beg_v    = 1'b1;
      beg      = ctsc_pkg::mk_res(ctsc_pkg::TK_END, 8'h00, apply ? line_app : line_r,
                                  '0);
      mode_nxt = ctsc_pkg::MD_IDLE;
      len_nxt  = '0;
      esc_nxt  = 1'b0;
    end else begin
      unique case (mode_r) inside
        ctsc_pkg::MD_IDLE: restart = 1'b1;
        ctsc_pkg::MD_IDENT: begin
          if (ctsc_pkg::is_alpha(c) || ctsc_pkg::is_digit(c) ||
              c == ctsc_pkg::CH_UNDERSCORE) begin
            len_nxt = len_inc;
          end else begin
            fin_v   = 1'b1;
            fin     = ctsc_pkg::mk_res(ctsc_pkg::TK_IDENT, 8'h00, line_r, len_r);
            restart = 1'b1;
          end
        end
        ctsc_pkg::MD_NINT, ctsc_pkg::MD_NFRAC, ctsc_pkg::MD_NEXP: begin
          if (ctsc_pkg::is_digit(c)) begin
            len_nxt = len_inc;
          end else if (c == ctsc_pkg::CH_DOT && mode_r == ctsc_pkg::MD_NINT) begin
            len_nxt  = len_inc;
            mode_nxt = ctsc_pkg::MD_NFRAC;
          end else if ((c == ctsc_pkg::CH_LOW_E || c == ctsc_pkg::CH_UP_E) &&
                       mode_r != ctsc_pkg::MD_NEXP) begin
            len_nxt  = len_inc;
            mode_nxt = ctsc_pkg::MD_NEXP;
          end else begin
            fin_v   = 1'b1;
            fin     = ctsc_pkg::mk_res(ctsc_pkg::TK_NUMBER, 8'h00, line_r, len_r);
            restart = 1'b1;
          end
        end
        ctsc_pkg::MD_STR: begin
          len_nxt = len_inc;
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (c == ctsc_pkg::CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (c == close_ch) begin
            fin_v    = 1'b1;
            fin      = ctsc_pkg::mk_res(ctsc_pkg::TK_STRING, 8'h00, line_r, len_inc);
            mode_nxt = ctsc_pkg::MD_IDLE;
          end
        end
        ctsc_pkg::MD_CMT: begin
          if (c == ctsc_pkg::CH_STAR) mode_nxt = ctsc_pkg::MD_CMTSTAR;
        end
        ctsc_pkg::MD_CMTSTAR: begin
          if (c == ctsc_pkg::CH_SLASH) mode_nxt = ctsc_pkg::MD_IDLE;
          else if (c != ctsc_pkg::CH_STAR) mode_nxt = ctsc_pkg::MD_CMT;
        end
        ctsc_pkg::MD_DBLANK, ctsc_pkg::MD_DDIG, ctsc_pkg::MD_DREST: begin
          if (c == ctsc_pkg::CH_NL) begin
            apply    = 1'b1;
            count_nl = 1'b0;
            mode_nxt = ctsc_pkg::MD_IDLE;
          end else if (mode_r == ctsc_pkg::MD_DREST) begin
            mode_nxt = ctsc_pkg::MD_DREST;
          end else if (ctsc_pkg::is_digit(c)) begin
            dval_nxt = dval_add;
            ddig_nxt = 1'b1;
            mode_nxt = ctsc_pkg::MD_DDIG;
          end else if (mode_r == ctsc_pkg::MD_DDIG ||
                       (c != ctsc_pkg::CH_SPACE && c != ctsc_pkg::CH_TAB)) begin
            mode_nxt = ctsc_pkg::MD_DREST;
          end
        end
        ctsc_pkg::MD_LT, ctsc_pkg::MD_GT: begin
          if ((mode_r == ctsc_pkg::MD_LT && c == ctsc_pkg::CH_LT) ||
              (mode_r == ctsc_pkg::MD_GT && c == ctsc_pkg::CH_GT)) begin
            len_nxt  = len_inc;
            mode_nxt = (mode_r == ctsc_pkg::MD_LT) ? ctsc_pkg::MD_LTLT : ctsc_pkg::MD_GTGT;
          end else begin
            fin_v   = 1'b1;
            fin     = ctsc_pkg::mk_res(sk, 8'h00, line_r, len_r);
            restart = 1'b1;
          end
        end
        default: begin
          if (mode_r == ctsc_pkg::MD_SLASH && c == ctsc_pkg::CH_STAR) begin
            mode_nxt = ctsc_pkg::MD_CMT;
            len_nxt  = '0;
          end else if (lk != ctsc_pkg::TK_IDENT) begin
            len_nxt  = len_inc;
            fin_v    = 1'b1;
            fin      = ctsc_pkg::mk_res(lk, 8'h00, line_r, len_inc);
            mode_nxt = ctsc_pkg::MD_IDLE;
          end else begin
            fin_v   = 1'b1;
            fin     = ctsc_pkg::mk_res(sk, 8'h00, line_r, len_r);
            restart = 1'b1;
          end
        end
      endcase

      // start of a new token
      if (restart) begin
        len_nxt  = NB'(1);
        mode_nxt = ctsc_pkg::MD_IDLE;
        if (ctsc_pkg::is_space(c)) begin
          mode_nxt = ctsc_pkg::MD_IDLE;
        end else if (ctsc_pkg::is_alpha(c) || c == ctsc_pkg::CH_UNDERSCORE) begin
          mode_nxt = ctsc_pkg::MD_IDENT;
        end else if (ctsc_pkg::is_digit(c)) begin
          mode_nxt = ctsc_pkg::MD_NINT;
        end else if (c == ctsc_pkg::CH_DQUOTE || c == ctsc_pkg::CH_SQUOTE) begin
          mode_nxt  = ctsc_pkg::MD_STR;
          quote_nxt = (c == ctsc_pkg::CH_SQUOTE);
          esc_nxt   = 1'b0;
        end else if (c == ctsc_pkg::CH_HASH) begin
          mode_nxt = ctsc_pkg::MD_DBLANK;
          dval_nxt = '0;
          ddig_nxt = 1'b0;
        end else begin
          case (c)
            ctsc_pkg::CH_SLASH: mode_nxt = ctsc_pkg::MD_SLASH;
            ctsc_pkg::CH_PLUS:  mode_nxt = ctsc_pkg::MD_PLUS;
            ctsc_pkg::CH_MINUS: mode_nxt = ctsc_pkg::MD_MINUS;
            ctsc_pkg::CH_STAR:  mode_nxt = ctsc_pkg::MD_STAR;
            ctsc_pkg::CH_PCT:   mode_nxt = ctsc_pkg::MD_PCT;
            ctsc_pkg::CH_LT:    mode_nxt = ctsc_pkg::MD_LT;
            ctsc_pkg::CH_GT:    mode_nxt = ctsc_pkg::MD_GT;
            ctsc_pkg::CH_EQ:    mode_nxt = ctsc_pkg::MD_EQ;
            ctsc_pkg::CH_BANG:  mode_nxt = ctsc_pkg::MD_BANG;
            ctsc_pkg::CH_BAR:   mode_nxt = ctsc_pkg::MD_BAR;
            ctsc_pkg::CH_AMP:   mode_nxt = ctsc_pkg::MD_AMP;
            ctsc_pkg::CH_CARET: mode_nxt = ctsc_pkg::MD_CARET;
            default: begin
              beg_v = 1'b1;
              beg   = ctsc_pkg::mk_res(ctsc_pkg::TK_CHAR, c, line_r, NB'(1));
            end
          endcase
        end
      end
    end

    if (apply && ddig_r) begin
      line_nxt = dval_r;
    end else if (count_nl && line_r != ctsc_pkg::LINE_MAX) begin
      line_nxt = line_r + LB'(1);
    end
  end

  // pack results in emission order, flag the last one
  always_comb begin
    push.n  = {1'b0, fin_v} + {1'b0, beg_v};
    push.r0 = fin_v ? fin : beg;
    push.r1 = beg;
    push.r0.last_of_run = !(fin_v && beg_v);
    push.r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ctsc_pkg::MD_IDLE;
      len_r   <= '0;
      line_r  <= LB'(1);
      dval_r  <= '0;
      ddig_r  <= 1'b0;
      quote_r <= 1'b0;
      esc_r   <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      line_r  <= line_nxt;
      dval_r  <= dval_nxt;
      ddig_r  <= ddig_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ctsc_res_fifo.sv -----
// ctsc_res_fifo: small result queue taking up to two results per cycle
// and handing out one per cycle while out_ready is high. Depends on ctsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctsc_res_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_en,
  input  wire ctsc_pkg::push_t   push,
  output logic                   room2,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ctsc_pkg::result_t      out_data
);

  localparam int AW = ctsc_pkg::FIFO_AW;
  localparam int CW = ctsc_pkg::FIFO_AW + 1;

  ctsc_pkg::result_t mem_r [ctsc_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        n_in;
  logic              pop;

  assign n_in      = push_en ? push.n : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign room2     = (cnt_r <= CW'(ctsc_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_nxt  = wr_r + AW'(n_in);
    rd_nxt  = rd_r + AW'(pop);
    cnt_nxt = cnt_r + CW'(n_in) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem_r[wr_r] <= push.r0;
    if (n_in == 2'd2) mem_r[wr_r + AW'(1)] <= push.r1;
  end

endmodule
`default_nettype wire

// ----- sv/c_source_token_scanner_top.sv -----
// c_source_token_scanner_top: C token scanner, one character per item in,
// token results out. Depends on ctsc_pkg, ctsc_in_if, ctsc_out_if, ctsc_core, ctsc_res_fifo.
//
// Takes one source character per cycle and reports identifiers, numbers,
// string/char constants, operators and single-character tokens, skipping
// comments and applying '#' line directives. A character is scanned in the
// cycle it is accepted, and its results (none, one or two) enter a
// four-entry result queue visible on the next cycle. Input is taken every
// cycle while the queue has two free entries; a character that ends one
// token and starts a single-character token yields two results. last_of_run
// marks the final result of a character; end_of_input flushes any open token
// and always yields an end result.
`timescale 1ns / 1ps
`default_nettype none
module c_source_token_scanner_top (
  input  wire logic clk,
  input  wire logic rst_n,
  ctsc_in_if.sink   in_ch,
  ctsc_out_if.source out_ch
);

  logic              fire;
  logic              room2;
  ctsc_pkg::push_t   push;
  ctsc_pkg::result_t head;

  assign in_ch.ready = room2;
  assign fire        = in_ch.valid && room2;

  ctsc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .c     (in_ch.char_code),
    .eoi   (in_ch.end_of_input),
    .push  (push)
  );

  ctsc_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (push),
    .room2     (room2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.char_value   = head.char_value;
  assign out_ch.line_number  = head.line_number;
  assign out_ch.token_length = head.token_length;
  assign out_ch.last_of_run  = head.last_of_run;

endmodule
`default_nettype wire
